// ===== hw/rtl/sem_pkg.sv =====
// Package with shared constants, types and codes of the Sobel edge magnitude block.
`timescale 1ns / 1ps
`default_nettype none
package sem_pkg;

  // Line buffer depth and the widths that follow from it.
  localparam int MAX_WIDTH = 1024;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int COL_W     = 10;
  localparam int ROW_W     = 16;
  localparam int WIDTH_W   = 11;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 16;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET  = WIDTH_W'(640);
  localparam logic [ROW_W-1:0]   HEIGHT_RESET = ROW_W'(480);
  localparam logic [WIDTH_W-1:0] WIDTH_LIMIT  = WIDTH_W'(MAX_WIDTH);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GRAD,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT,
    ST_EMIT
  } sem_state_t;

  typedef struct packed {
    logic accept;
    logic grad;
    logic square;
    logic sum;
    logic root;
    logic pop;
  } sem_cmd_t;

  typedef struct packed {
    logic root_done;
    logic pend_any;
    logic pend_last;
  } sem_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sem_pix_in_if.sv =====
// Interface of the input pixel channel.
`timescale 1ns / 1ps
`default_nettype none
interface sem_pix_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  modport source (output valid, output red, output green, output blue, output alpha,
                  input ready);
  modport sink (input valid, input red, input green, input blue, input alpha,
                output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/sem_pix_out_if.sv =====
// Interface of the result pixel channel.
`timescale 1ns / 1ps
`default_nettype none
interface sem_pix_out_if;
  logic                       valid;
  logic                       ready;
  logic [sem_pkg::COL_W-1:0]  out_col;
  logic [sem_pkg::ROW_W-1:0]  out_row;
  logic [7:0]                 magnitude;
  logic [7:0]                 out_alpha;
  logic                       last;
  modport source (output valid, output out_col, output out_row, output magnitude,
                  output out_alpha, output last, input ready);
  modport sink (input valid, input out_col, input out_row, input magnitude,
                input out_alpha, input last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/sem_cfg_if.sv =====
// Interface of the configuration write channel.
`timescale 1ns / 1ps
`default_nettype none
interface sem_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [sem_pkg::CFG_IDX_W-1:0] index;
  logic [sem_pkg::CFG_DAT_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/sem_ctrl.sv =====
// Controller state machine that sequences one pixel through the datapath.
`timescale 1ns / 1ps
`default_nettype none
module sem_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire sem_pkg::sem_status_t status,
  output sem_pkg::sem_cmd_t        cmd
);

  sem_pkg::sem_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sem_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sem_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = sem_pkg::ST_GRAD;
      end
      sem_pkg::ST_GRAD:   state_nxt = sem_pkg::ST_SQUARE;
      sem_pkg::ST_SQUARE: state_nxt = sem_pkg::ST_SUM;
      sem_pkg::ST_SUM:    state_nxt = sem_pkg::ST_ROOT;
      sem_pkg::ST_ROOT: begin
        if (status.root_done) begin
          state_nxt = status.pend_any ? sem_pkg::ST_EMIT : sem_pkg::ST_IDLE;
        end
      end
      sem_pkg::ST_EMIT: begin
        if (out_ready && status.pend_last) state_nxt = sem_pkg::ST_IDLE;
      end
      default: state_nxt = sem_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd        = '0;
    unique case (state_r)
      sem_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      sem_pkg::ST_GRAD:   cmd.grad   = 1'b1;
      sem_pkg::ST_SQUARE: cmd.square = 1'b1;
      sem_pkg::ST_SUM:    cmd.sum    = 1'b1;
      sem_pkg::ST_ROOT:   cmd.root   = 1'b1;
      sem_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        cmd.pop   = out_ready;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sem_datapath.sv =====
// Datapath: counters, line buffers, window, gradients, square root and result select.
`timescale 1ns / 1ps
`default_nettype none
module sem_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire sem_pkg::sem_cmd_t                 cmd,
  output sem_pkg::sem_status_t                   status,
  input  wire logic                              cfg_we,
  input  wire logic [sem_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [sem_pkg::CFG_DAT_W-1:0]     cfg_data,
  input  wire logic [7:0]                        in_red,
  input  wire logic [7:0]                        in_green,
  input  wire logic [7:0]                        in_blue,
  input  wire logic [7:0]                        in_alpha,
  output logic [sem_pkg::COL_W-1:0]              out_col,
  output logic [sem_pkg::ROW_W-1:0]              out_row,
  output logic [7:0]                             out_magnitude,
  output logic [7:0]                             out_alpha,
  output logic                                   out_last
);

  localparam int CW = sem_pkg::COL_W;
  localparam int RW = sem_pkg::ROW_W;
  localparam int WW = sem_pkg::WIDTH_W;
  localparam int AW = sem_pkg::ADDR_W;

  // Configuration registers and their effective values.
  logic [WW-1:0] width_r;
  logic [RW-1:0] height_r;
  logic [WW-1:0] w_eff;
  logic [RW-1:0] h_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= sem_pkg::WIDTH_RESET;
      height_r <= sem_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == sem_pkg::CFG_IMAGE_WIDTH)  width_r  <= cfg_data[WW-1:0];
      if (cfg_index == sem_pkg::CFG_IMAGE_HEIGHT) height_r <= cfg_data[RW-1:0];
    end
  end

  always_comb begin
    if (width_r == '0)                        w_eff = WW'(1);
    else if (width_r > sem_pkg::WIDTH_LIMIT)  w_eff = sem_pkg::WIDTH_LIMIT;
    else                                      w_eff = width_r;
    h_eff = (height_r == '0) ? RW'(1) : height_r;
  end

  // Raster position. A size change may leave the counters out of range, so the
  // position of the new pixel is settled before it is used.
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [CW-1:0] x_sel;
  logic [RW-1:0] y_sel;
  logic [RW:0]   y_pre;
  logic [WW-1:0] x_inc;
  logic [RW:0]   y_inc;
  logic [CW-1:0] col_nxt;
  logic [RW-1:0] row_nxt;

  always_comb begin
    if ({1'b0, col_r} >= w_eff) begin
      x_sel = '0;
      y_pre = {1'b0, row_r} + (RW+1)'(1);
    end else begin
      x_sel = col_r;
      y_pre = {1'b0, row_r};
    end
    y_sel = (y_pre >= {1'b0, h_eff}) ? '0 : y_pre[RW-1:0];
    x_inc = {1'b0, x_sel} + WW'(1);
    y_inc = {1'b0, y_sel} + (RW+1)'(1);
    if (x_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (y_inc >= {1'b0, h_eff}) ? '0 : y_inc[RW-1:0];
    end else begin
      col_nxt = x_inc[CW-1:0];
      row_nxt = y_sel;
    end
  end

  logic [CW-1:0] x_r;
  logic [RW-1:0] y_r;
  logic [7:0]    red_r, green_r, blue_r, alpha_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_r     <= x_sel;
      y_r     <= y_sel;
      red_r   <= in_red;
      green_r <= in_green;
      blue_r  <= in_blue;
      alpha_r <= in_alpha;
    end
  end

  // Line buffers: read at the pixel's column when it is taken, written back
  // at the same column in the gradient cycle.
  logic [7:0] gray_one_mem [sem_pkg::MAX_WIDTH];
  logic [7:0] gray_two_mem [sem_pkg::MAX_WIDTH];
  logic [7:0] alpha_one_mem [sem_pkg::MAX_WIDTH];
  logic [7:0] up1_r, up2_r, a_up_r;
  logic [7:0] gray;

  always_ff @(posedge clk) begin
    if (cmd.grad) gray_one_mem[x_r[AW-1:0]] <= gray;
    if (cmd.accept) up1_r <= gray_one_mem[x_sel[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.grad) gray_two_mem[x_r[AW-1:0]] <= up1_r;
    if (cmd.accept) up2_r <= gray_two_mem[x_sel[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.grad) alpha_one_mem[x_r[AW-1:0]] <= alpha_r;
    if (cmd.accept) a_up_r <= alpha_one_mem[x_sel[AW-1:0]];
  end

  // Gray is the sum times 683/2048, exact for sums up to 765.
  logic [9:0]  rgb_sum;
  logic [19:0] gray_prod;

  always_comb begin
    rgb_sum   = 10'(red_r) + 10'(green_r) + 10'(blue_r);
    gray_prod = 20'(rgb_sum) * 20'(683);
    gray      = gray_prod[18:11];
  end

  // Window: two older columns of the three rows around the centre.
  logic [7:0] t0_r, t1_r, m0_r, m1_r, b0_r, b1_r;
  logic [7:0] alpha_held_r;
  logic [7:0] centre_alpha_r;
  logic signed [11:0] gx, gy, gx_r, gy_r;

  always_comb begin
    gx = (12'(up2_r) + (12'(up1_r) << 1) + 12'(gray))
       - (12'(t0_r) + (12'(m0_r) << 1) + 12'(b0_r));
    gy = (12'(b0_r) + (12'(b1_r) << 1) + 12'(gray))
       - (12'(t0_r) + (12'(t1_r) << 1) + 12'(up2_r));
  end

  always_ff @(posedge clk) begin
    if (cmd.grad) begin
      t0_r <= t1_r;
      m0_r <= m1_r;
      b0_r <= b1_r;
      t1_r <= up2_r;
      m1_r <= up1_r;
      b1_r <= gray;
      gx_r <= gx;
      gy_r <= gy;
      centre_alpha_r <= alpha_held_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_held_r <= '0;
    end else if (cmd.grad) begin
      alpha_held_r <= a_up_r;
    end
  end

  // Pending results, lowest bit first: the pixel up and left, the end of the
  // row above, and the last row.
  logic [2:0] pend_r;
  logic [2:0] pend_calc;
  logic       interior_r;
  logic [WW-1:0] w_last;

  always_comb begin
    w_last       = w_eff - WW'(1);
    pend_calc[0] = (x_r != '0) && (y_r != '0);
    pend_calc[1] = ({1'b0, x_r} == w_last) && (y_r != '0);
    pend_calc[2] = (y_r == h_eff - RW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (cmd.grad) begin
      pend_r <= pend_calc;
    end else if (cmd.pop) begin
      pend_r <= pend_r & (pend_r - 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.grad) interior_r <= (x_r >= CW'(2)) && (y_r >= RW'(2));
  end

  // Squares, sum and a bit-serial square root of the low 16 bits.
  logic signed [23:0] sqx_full, sqy_full;
  logic [19:0] sqx_r, sqy_r;
  logic [20:0] sq_sum;
  logic [15:0] root_v_r;
  logic        clamp_r;
  logic [7:0]  res_r;
  logic [2:0]  bit_r;
  logic [7:0]  trial;
  logic [15:0] trial_sq;

  always_comb begin
    sqx_full = 24'(gx_r) * 24'(gx_r);
    sqy_full = 24'(gy_r) * 24'(gy_r);
    sq_sum   = 21'(sqx_r) + 21'(sqy_r);
    trial    = res_r | (8'd1 << bit_r);
    trial_sq = 16'(trial) * 16'(trial);
  end

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      sqx_r <= sqx_full[19:0];
      sqy_r <= sqy_full[19:0];
    end
    if (cmd.sum) begin
      clamp_r  <= (sq_sum[20:16] != '0);
      root_v_r <= sq_sum[15:0];
      res_r    <= '0;
      bit_r    <= 3'd7;
    end else if (cmd.root) begin
      if (trial_sq <= root_v_r) res_r <= trial;
      bit_r <= bit_r - 3'd1;
    end
  end

  assign status.root_done = (bit_r == 3'd0);
  assign status.pend_any  = (pend_r != '0);
  assign status.pend_last = ((pend_r & (pend_r - 3'd1)) == '0);

  // Result select from the lowest pending bit.
  logic [RW-1:0] y_less;

  always_comb begin
    y_less   = y_r - RW'(1);
    out_last = status.pend_last;
    if (pend_r[0]) begin
      out_col       = x_r - CW'(1);
      out_row       = y_less;
      out_magnitude = interior_r ? (clamp_r ? 8'd255 : res_r) : 8'd0;
      out_alpha     = interior_r ? centre_alpha_r : 8'd255;
    end else if (pend_r[1]) begin
      out_col       = w_last[CW-1:0];
      out_row       = y_less;
      out_magnitude = 8'd0;
      out_alpha     = 8'd255;
    end else begin
      out_col       = x_r;
      out_row       = y_r;
      out_magnitude = 8'd0;
      out_alpha     = 8'd255;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sobel_edge_magnitude.sv =====
// Top level of the Sobel edge magnitude block over a raster RGBA pixel stream.
// The controller walks each accepted pixel word through the gradient, square, sum
// and square root steps before its first result word is offered.
// A new pixel word is taken only after all results of the last one (0 to 3) are
// taken; the eight-step square root loop and the one-pixel-at-a-time sequencer set the pace.
// Reset (synchronous, rst_n low): counters at zero, width 640, height 480;
// line buffers and window are not cleared and take no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module sobel_edge_magnitude (
  input  wire logic     clk,
  input  wire logic     rst_n,
  sem_pix_in_if.sink    in_px,
  sem_pix_out_if.source out_px,
  sem_cfg_if.sink       cfg_wr
);

  // The controller walks each pixel word through gradient, square, sum, square root
  // and, when results are pending, emit steps; the datapath holds all storage and arithmetic.
  sem_pkg::sem_cmd_t    cmd;
  sem_pkg::sem_status_t status;

  // Configuration words are always taken; the user must send them only while the
  // block is idle, as the block itself does not enforce this and has no stall.
  assign cfg_wr.ready = 1'b1;

  sem_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_px.valid),
    .in_ready  (in_px.ready),
    .out_valid (out_px.valid),
    .out_ready (out_px.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Result fields are selected combinationally from registers that hold still while a
  // result word waits, so the output channel needs no extra stage.
  sem_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg_wr.valid),
    .cfg_index     (cfg_wr.index),
    .cfg_data      (cfg_wr.data),
    .in_red        (in_px.red),
    .in_green      (in_px.green),
    .in_blue       (in_px.blue),
    .in_alpha      (in_px.alpha),
    .out_col       (out_px.out_col),
    .out_row       (out_px.out_row),
    .out_magnitude (out_px.magnitude),
    .out_alpha     (out_px.out_alpha),
    .out_last      (out_px.last)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/sem_checker.sv =====
// Port checker of the Sobel edge magnitude block and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sem_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic                      out_last,
  input wire logic [sem_pkg::COL_W-1:0] out_col,
  input wire logic [sem_pkg::ROW_W-1:0] out_row,
  input wire logic [7:0]                magnitude
);

  // A stalled result word stays valid and keeps its column and row.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_col) && $stable(out_row))
    else $error("stalled result word changed");

  // No pixel word is taken while results are being delivered.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while results pending");

  // A pixel word being taken is not directly followed by a result word.
  a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid)
    else $error("result right after accept");

  // The first row and column are border pixels with zero magnitude.
  a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && magnitude != 8'd0 |-> out_col != '0 && out_row != '0)
    else $error("nonzero magnitude on border");

  // After the last result word goes, the block is ready for a pixel.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> in_ready)
    else $error("not idle after last result");

endmodule

bind sobel_edge_magnitude sem_checker u_sem_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_px.valid),
  .in_ready  (in_px.ready),
  .out_valid (out_px.valid),
  .out_ready (out_px.ready),
  .out_last  (out_px.last),
  .out_col   (out_px.out_col),
  .out_row   (out_px.out_row),
  .magnitude (out_px.magnitude)
);
`default_nettype wire
